// ===== sv/mds_pkg.sv =====
// Shared types and constants for the mail body dot stuffer.
// No dependencies; every other file imports this package.
package mds_pkg;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_DOT = 8'h2E;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_EOM  = 1'b1;

	// Input word: one body byte or an end-of-message mark.
	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_word_t;

	// Output word: one byte for the wire.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_word_t;

	// Classified job passed from front to back.
	// Data job: lead set means a CR or DOT goes out before the byte.
	// End job: lead set means CR LF goes out before the terminator.
	typedef struct packed {
		logic       eom;
		logic       lead;
		logic [7:0] data;
	} job_t;

	// Bytes of the closing sequence CR LF . CR LF by position.
	function automatic logic [7:0] eom_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0: b = CH_CR;
			3'd1: b = CH_LF;
			3'd2: b = CH_DOT;
			3'd3: b = CH_CR;
			3'd4: b = CH_LF;
			default: b = CH_LF;
		endcase
		return b;
	endfunction

endpackage

// ===== sv/mds_front.sv =====
// Front end: accepts input words, tracks the last byte sent and classifies each word.
// Depends on mds_pkg.
module mds_front import mds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	input  logic     q_full,
	output logic     push,
	output job_t     push_job
);

	logic [7:0] prev_q;
	logic       is_lf;
	logic       is_dot;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign is_lf    = (in_data.data_byte == CH_LF);
	assign is_dot   = (in_data.data_byte == CH_DOT);

	always_comb begin
		push_job.eom  = (in_data.command == CMD_EOM);
		push_job.data = in_data.data_byte;
		if (in_data.command == CMD_EOM) begin
			push_job.lead = (prev_q != CH_LF);
		end else begin
			push_job.lead = (is_lf && prev_q != CH_CR) || (is_dot && prev_q == CH_LF);
		end
	end

	// The last byte of any data job is the data byte itself; an end clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 8'h00;
		end else if (push) begin
			prev_q <= (in_data.command == CMD_EOM) ? 8'h00 : in_data.data_byte;
		end
	end

endmodule

// ===== sv/mds_queue.sv =====
// Small job queue between front and back.
// Depends on mds_pkg for the job type.
module mds_queue import mds_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/mds_back.sv =====
// Back end: expands each job into wire bytes, one per cycle while not stalled, into an output register.
// Depends on mds_pkg.
module mds_back import mds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  job_t      head_job,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_q;
	logic [2:0] len;
	logic       last;
	logic       advance;
	logic [7:0] cur_byte;
	logic [7:0] prefix;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		if (head_job.eom) begin
			len = head_job.lead ? 3'd5 : 3'd3;
		end else begin
			len = head_job.lead ? 3'd2 : 3'd1;
		end
	end

	assign last    = (idx_q == len - 3'd1);
	assign advance = head_valid && (!out_valid_q || out_ready);
	assign pop     = advance && last;
	assign prefix  = (head_job.data == CH_LF) ? CH_CR : CH_DOT;

	always_comb begin
		if (head_job.eom) begin
			// skip the leading CR LF when the line is already closed
			cur_byte = eom_byte(idx_q + (head_job.lead ? 3'd0 : 3'd2));
		end else if (head_job.lead && idx_q == 3'd0) begin
			cur_byte = prefix;
		end else begin
			cur_byte = head_job.data;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.out_byte    <= cur_byte;
			out_q.last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/mail_body_dot_stuffer_core.sv =====
// Mail body dot stuffer: CR LF normalization and dot transparency for a body stream.
// An accepted word is pushed into the job queue, then expanded into the output register.
// Throughput: one output byte per cycle while out_ready holds; a word yields 1-2 bytes, an end mark 3 or 5.
// Input is taken every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset (arst_n low, asynchronous) clears the last-sent byte, the queue and the output valid flag.
// Depends on mds_pkg, mds_front, mds_queue and mds_back.
module mail_body_dot_stuffer_core import mds_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	mds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	mds_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	mds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for mail_body_dot_stuffer_core: random and directed body words with checked output.
// Depends on mds_pkg and the core RTL.
module testbench import mds_pkg::*;;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 200;
	localparam int PHASE_WORDS    = 24;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	in_word_t  pending_words[$];
	out_word_t wire_bytes_due[$];
	logic [7:0] last_wire_byte = 8'h00;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int staged_words = 0;
	int error_count = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	mail_body_dot_stuffer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the wire bytes one accepted word produces and update the last-sent byte.
	function automatic void stuff_word(input in_word_t w);
		logic [7:0] run [5];
		int n = 0;
		if (w.command == CMD_DATA) begin
			if (w.data_byte == CH_LF && last_wire_byte != CH_CR) begin
				run[n] = CH_CR;
				n++;
			end else if (w.data_byte == CH_DOT && last_wire_byte == CH_LF) begin
				run[n] = CH_DOT;
				n++;
			end
			run[n] = w.data_byte;
			n++;
			last_wire_byte = w.data_byte;
		end else begin
			if (last_wire_byte != CH_LF) begin
				run[n] = CH_CR;
				run[n + 1] = CH_LF;
				n += 2;
			end
			run[n] = CH_DOT;
			run[n + 1] = CH_CR;
			run[n + 2] = CH_LF;
			n += 3;
			last_wire_byte = 8'h00;
		end
		for (int i = 0; i < n; i++)
			wire_bytes_due.push_back(out_word_t'{out_byte: run[i], last_of_run: (i == n - 1)});
	endfunction

	// Driver: offer the next pending word; hold it until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				stuff_word(in_data);
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted byte against the oldest one due, then pick out_ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (wire_bytes_due.size() == 0) begin
					$error("unexpected output word: out_byte %h last_of_run %b",
						out_data.out_byte, out_data.last_of_run);
					error_count++;
				end else begin
					out_word_t due;
					due = wire_bytes_due.pop_front();
					if (out_data.out_byte !== due.out_byte) begin
						$error("out_byte: expected %h, actual %h", due.out_byte, out_data.out_byte);
						error_count++;
					end
					if (out_data.last_of_run !== due.last_of_run) begin
						$error("last_of_run: expected %b, actual %b",
							due.last_of_run, out_data.last_of_run);
						error_count++;
					end
				end
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_req && !hold_done) begin
				// hold off long enough for the job queue to fill and stall the input
				out_ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic queue_word(input logic cmd, input logic [7:0] b);
		pending_words.push_back(in_word_t'{command: cmd, data_byte: b});
		staged_words++;
	endtask

	// Bias toward the bytes that matter: CR, LF and dot.
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1: b = CH_LF;
			2, 3: b = CH_CR;
			4, 5: b = CH_DOT;
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	task automatic queue_message();
		int len;
		len = $urandom_range(10);
		for (int i = 0; i < len; i++)
			queue_word(CMD_DATA, body_byte());
		queue_word(CMD_EOM, 8'($urandom_range(255)));
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || in_valid || wire_bytes_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// leading dot, bare LF, dot after LF, lone CR, CR LF
		queue_word(CMD_DATA, CH_DOT);
		queue_word(CMD_DATA, CH_LF);
		queue_word(CMD_DATA, CH_DOT);
		queue_word(CMD_DATA, CH_CR);
		queue_word(CMD_DATA, 8'h78);
		queue_word(CMD_DATA, CH_CR);
		queue_word(CMD_DATA, CH_LF);
		// end right after LF, then a repeated end
		queue_word(CMD_EOM, 8'h00);
		queue_word(CMD_EOM, 8'hFF);
		// data after end starts a fresh message
		queue_word(CMD_DATA, CH_LF);
		queue_word(CMD_DATA, 8'h00);
		queue_word(CMD_DATA, 8'hFF);
		queue_word(CMD_EOM, 8'h55);
		queue_word(CMD_DATA, CH_DOT);
		queue_word(CMD_DATA, CH_LF);
		queue_word(CMD_DATA, CH_LF);
		queue_word(CMD_DATA, CH_DOT);
		queue_word(CMD_EOM, 8'hAA);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			int target;
			case (phase)
				1: begin sender_idle_pct = 55; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 55; end
				3: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
				default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
			endcase
			if (phase == 0)
				hold_req = 1'b1;
			target = staged_words + PHASE_WORDS;
			while (staged_words < target)
				queue_message();
			drain();
		end

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mds_pkg.sv
sv/mds_front.sv
sv/mds_queue.sv
sv/mds_back.sv
sv/mail_body_dot_stuffer_core.sv
sim/testbench.sv
